FILE: hdl/plit_pkg.sv
// Package for the piecewise linear interpolation table.
// Holds the request and response types, status codes and state encoding.
// No dependencies.
package plit_pkg;

    localparam int unsigned DefTableDepth = 64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_ZERO_WIDE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_QUERY  = 1'b1
    } t_func;

    typedef struct packed {
        logic               func;
        logic        [31:0] frequency;
        logic signed [31:0] point_voltage;
    } t_req;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic        [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic        [31:0] freq;
        logic signed [31:0] volt;
    } t_point;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_QRY_RD,
        S_QRY_CMP,
        S_MUL0,
        S_MUL1,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    function automatic logic point_less(input t_point a, input t_point b);
        if (a.freq != b.freq) begin
            return a.freq < b.freq;
        end
        return a.volt < b.volt;
    endfunction

endpackage

FILE: hdl/plit_mem.sv
// Breakpoint memory: one write port, one read port, registered read data.
// Depends on plit_pkg.
module plit_mem
    import plit_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefTableDepth,
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_point        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_point        o_rd_data
);

    t_point r_mem [TABLE_DEPTH];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/plit_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Gives the low 32 bits of the quotient. Depends on plit_pkg.
module plit_div
    import plit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_dq;
    logic [31:0] r_div;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem[31:0], r_dq[63]};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!rem_sub[32]) begin
                r_rem <= rem_sub;
                r_dq  <= {r_dq[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_dq  <= {r_dq[62:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq[31:0];

endmodule

FILE: hdl/piecewise_linear_interp_table.sv
// Top level of the piecewise linear interpolation table.
// Depends on plit_pkg, plit_mem and plit_div.
//
// Requests arrive on i_valid/o_ready with a t_req payload on i_data; one
// response per request leaves on o_valid/i_ready with a t_rsp payload.
// An insert places a breakpoint in sorted order; a query interpolates
// between the two bracketing breakpoints. One request is worked at a time.
// An insert runs the read-compare-write shift loop through the breakpoint
// memory. A query runs a linear scan and, when an interpolation is made,
// the multiply states S_MUL0 and S_MUL1 and then the bit-serial divider.
// The response is held in an output register; the next request is taken
// while it waits, and a finished request waits in the core until the
// output register is free. Reset empties the table and drops any pending
// response; the memory contents need no clearing.
module piecewise_linear_interp_table
    import plit_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    t_req          r_req;
    t_point        r_prev;
    t_point        r_cur;
    logic [63:0]   r_acc;
    t_rsp          r_res;
    logic          r_out_valid;
    t_rsp          r_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_point        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_point        rd_data;
    t_point        new_pt;
    t_point        key_pt;
    logic          div_start;
    logic          div_done;
    logic [31:0]   div_q;
    logic [63:0]   mag;
    logic [31:0]   mul_w;
    logic signed [31:0] mul_v;
    logic signed [65:0] prod;
    logic [CW-1:0] idx_m1;
    logic          out_free;

    assign new_pt   = '{freq: r_req.frequency, volt: r_req.point_voltage};
    assign key_pt   = '{freq: r_req.frequency, volt: '0};
    assign idx_m1   = r_idx - CW'(1);
    assign out_free = !r_out_valid || i_ready;
    assign mag      = r_acc[63] ? (64'd0 - r_acc) : r_acc;

    plit_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    plit_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(mag),
        .i_divisor (r_cur.freq - r_prev.freq),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.func == FN_QUERY) begin
                        n_state = S_QRY_RD;
                    end else if (r_count == Full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD:  n_state = (r_idx == '0) ? S_DONE : S_INS_CMP;
            S_INS_CMP: n_state = point_less(new_pt, rd_data) ? S_INS_RD : S_DONE;
            S_QRY_RD:  n_state = (r_idx == r_count) ? S_DONE : S_QRY_CMP;
            S_QRY_CMP: begin
                if (point_less(rd_data, key_pt)) begin
                    n_state = S_QRY_RD;
                end else if (r_idx == '0 || rd_data.freq == r_prev.freq) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0:      n_state = S_MUL1;
            S_MUL1:      n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  n_state = div_done ? S_DONE : S_DIV_WAIT;
            S_DONE:      n_state = out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_idx[AW-1:0];
        wr_data   = new_pt;
        rd_en     = 1'b0;
        rd_addr   = r_idx[AW-1:0];
        div_start = 1'b0;
        mul_v     = r_prev.volt;
        mul_w     = r_cur.freq - r_req.frequency;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_INS_RD: begin
                if (r_idx == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m1[AW-1:0];
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (point_less(new_pt, rd_data)) begin
                    wr_data = rd_data;
                end
            end
            S_QRY_RD: rd_en = (r_idx != r_count);
            S_MUL1: begin
                mul_v = r_cur.volt;
                mul_w = r_req.frequency - r_prev.freq;
            end
            S_DIV_START: div_start = 1'b1;
            default: ;
        endcase
        prod = mul_v * $signed({2'b00, mul_w});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_INS_RD && r_idx == '0) ||
                (r_state == S_INS_CMP && !point_less(new_pt, rd_data))) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req <= i_data;
                r_idx <= (i_data.func == FN_QUERY) ? '0 : r_count;
                r_res <= '{interp_value: '0,
                           status: (i_data.func == FN_INSERT && r_count == Full) ?
                                   ST_FULL : ST_OK};
            end
            S_INS_CMP: begin
                if (point_less(new_pt, rd_data)) begin
                    r_idx <= idx_m1;
                end
            end
            S_QRY_RD: begin
                if (r_idx == r_count) begin
                    r_res.status <= ST_RANGE;
                end
            end
            S_QRY_CMP: begin
                r_cur <= rd_data;
                if (point_less(rd_data, key_pt)) begin
                    r_prev <= rd_data;
                    r_idx  <= r_idx + CW'(1);
                end else if (r_idx == '0) begin
                    r_res.status <= ST_RANGE;
                end else if (rd_data.freq == r_prev.freq) begin
                    r_res.status <= ST_ZERO_WIDE;
                end
            end
            S_MUL0: r_acc <= prod[63:0];
            S_MUL1: r_acc <= r_acc + prod[63:0];
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_res.interp_value <= r_acc[63] ? (32'd0 - div_q) : div_q;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
